[design/gnf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnf_pkg: shared types and constants for the fractal gradient noise block.
// Holds the register map, the configuration bundle handed to every octave
// lane, and the reciprocal table used to normalize the octave sum.
// ----------------------------------------------------------------------------
package gnf_pkg;

  localparam int TIME_BITS_DEF   = 24;
  localparam int MAX_OCTAVES_DEF = 8;

  localparam int POS_W       = 16;
  localparam int FRAC_W      = 8;
  localparam int SEED_W      = 8;
  localparam int OCT_W       = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int REG_IDX_W   = 3;
  localparam int SIGN_N      = 256;
  localparam int SAMPLE_W    = 8;
  localparam int SUM_W       = 10;
  localparam int VALUE_W     = 8;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 23;

  localparam logic [9:0]         FADE_BASE = 10'd768;
  localparam logic [VALUE_W-1:0] MID_VALUE = 8'd128;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SEED    = 3'd0,
    REG_OCTAVES = 3'd1,
    REG_SIGN0   = 3'd2,
    REG_SIGN1   = 3'd3,
    REG_SIGN2   = 3'd4,
    REG_SIGN3   = 3'd5
  } gnf_reg_t;

  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [SIGN_N-1:0] signs;
  } gnf_cfg_t;

  // Reciprocal ceil(2^23 / amp_sum) for each octave count; exact truncating
  // quotient for every dividend below 2^15.
  function automatic logic [RECIP_W-1:0] gnf_recip(input logic [OCT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd43691;
      4'd3:    r = 17'd37450;
      4'd4:    r = 17'd34953;
      4'd5:    r = 17'd33826;
      4'd6:    r = 17'd33289;
      4'd7:    r = 17'd33027;
      4'd8:    r = 17'd32897;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[design/gnf_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnf_lane: one noise octave, three register stages.
// Stage one looks up both gradients and squares the fraction, stage two
// forms the cubic fade and the lattice contributions, stage three blends,
// clamps and scales the sample by the octave amplitude.
// ----------------------------------------------------------------------------
module gnf_lane #(
  parameter int SHIFT = 0
) (
  input  logic                                  clk,
  input  logic [gnf_pkg::POS_W-1:0]             pos,
  input  gnf_pkg::gnf_cfg_t                     cfg,
  output logic signed [gnf_pkg::SAMPLE_W-1:0]   sample
);

  localparam logic [9:0] FADE_BASE_L = gnf_pkg::FADE_BASE;

  logic [gnf_pkg::POS_W-1:0]  p;
  logic [gnf_pkg::FRAC_W-1:0] lat;
  logic [gnf_pkg::FRAC_W-1:0] frac;
  logic [gnf_pkg::FRAC_W-1:0] idx0;
  logic [gnf_pkg::FRAC_W-1:0] idx1;

  logic [gnf_pkg::FRAC_W-1:0] frac_q;
  logic [15:0]                sq_q;
  logic [9:0]                 fade_m_q;
  logic                       g0_q;
  logic                       g1_q;

  logic [25:0]                fade_prod;
  logic signed [8:0]          v0;
  logic signed [9:0]          v1;
  logic signed [9:0]          diff;
  logic [7:0]                 s_q;
  logic signed [8:0]          v0_q;
  logic signed [9:0]          diff_q;

  logic signed [18:0]         s_ext;
  logic signed [18:0]         d_ext;
  logic signed [18:0]         prod;
  logic signed [18:0]         prod_sh;
  logic signed [10:0]         n;
  logic signed [10:0]         half;
  logic signed [7:0]          clamped;

  assign p    = pos << SHIFT;
  assign lat  = p[15:8];
  assign frac = p[7:0];
  assign idx0 = lat ^ cfg.seed;
  assign idx1 = (lat + 8'd1) ^ cfg.seed;

  always_ff @(posedge clk) begin
    frac_q   <= frac;
    sq_q     <= 16'(frac) * 16'(frac);
    fade_m_q <= FADE_BASE_L - {1'b0, frac, 1'b0};
    g0_q     <= cfg.signs[idx0];
    g1_q     <= cfg.signs[idx1];
  end

  assign fade_prod = 26'(sq_q) * 26'(fade_m_q);

  always_comb begin
    v0   = g0_q ? $signed({1'b0, frac_q}) : -$signed({1'b0, frac_q});
    v1   = g1_q ? ($signed({2'b00, frac_q}) - 10'sd256)
                : (10'sd256 - $signed({2'b00, frac_q}));
    diff = v1 - $signed({v0[8], v0});
  end

  always_ff @(posedge clk) begin
    s_q    <= fade_prod[23:16];
    v0_q   <= v0;
    diff_q <= diff;
  end

  always_comb begin
    s_ext   = $signed({11'd0, s_q});
    d_ext   = $signed({{9{diff_q[9]}}, diff_q});
    prod    = s_ext * d_ext;
    prod_sh = prod >>> 8;
    n       = $signed({{2{v0_q[8]}}, v0_q}) + prod_sh[10:0];
    half    = n >>> 1;
    if (half > 11'sd127) begin
      clamped = 8'sd127;
    end else if (half < -11'sd128) begin
      clamped = -8'sd128;
    end else begin
      clamped = half[7:0];
    end
  end

  always_ff @(posedge clk) begin
    sample <= clamped >>> SHIFT;
  end

endmodule

[design/gnf_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnf_norm: octave sum and normalization, three register stages.
// Sums the enabled octave samples, divides the scaled magnitude by the summed
// amplitudes through a reciprocal multiply, then restores the sign, adds the
// midpoint and clamps to the 8-bit range (midpoint alone for zero octaves).
// ----------------------------------------------------------------------------
module gnf_norm #(
  parameter int MAX_OCTAVES = gnf_pkg::MAX_OCTAVES_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  input  logic [MAX_OCTAVES-1:0][gnf_pkg::SAMPLE_W-1:0]   samples,
  input  logic [gnf_pkg::OCT_W-1:0]                       octaves,
  output logic                                            out_valid,
  output logic [gnf_pkg::VALUE_W-1:0]                     value
);

  logic signed [gnf_pkg::SUM_W-1:0] sum;
  logic [gnf_pkg::SUM_W-1:0]        abs_sum;
  logic                             vld_a;
  logic [8:0]                       mag_q;
  logic                             neg_a;
  logic                             zero_a;
  logic [gnf_pkg::RECIP_W-1:0]      recip_q;

  logic [15:0]                      dividend;
  logic [32:0]                      quo_prod;
  logic                             vld_b;
  logic [8:0]                       quo_q;
  logic                             neg_b;
  logic                             zero_b;

  logic signed [10:0]               res;
  logic [gnf_pkg::VALUE_W-1:0]      value_next;

  always_comb begin
    sum = '0;
    for (int k = 0; k < MAX_OCTAVES; k++) begin
      if (k < int'(octaves)) begin
        sum = sum + $signed({{2{samples[k][7]}}, samples[k]});
      end
    end
    abs_sum = sum[gnf_pkg::SUM_W-1] ? 10'(-sum) : 10'(sum);
  end

  always_ff @(posedge clk) begin
    mag_q   <= abs_sum[8:0];
    neg_a   <= sum[gnf_pkg::SUM_W-1];
    zero_a  <= (octaves == '0);
    recip_q <= gnf_pkg::gnf_recip(octaves);
  end

  assign dividend = {mag_q, 7'd0};
  assign quo_prod = 33'(dividend) * 33'(recip_q);

  always_ff @(posedge clk) begin
    quo_q  <= quo_prod[31:gnf_pkg::RECIP_SHIFT];
    neg_b  <= neg_a;
    zero_b <= zero_a;
  end

  always_comb begin
    if (neg_b) begin
      res = $signed({3'd0, gnf_pkg::MID_VALUE}) - $signed({2'd0, quo_q});
    end else begin
      res = $signed({3'd0, gnf_pkg::MID_VALUE}) + $signed({2'd0, quo_q});
    end
    if (zero_b) begin
      value_next = gnf_pkg::MID_VALUE;
    end else if (res < 11'sd0) begin
      value_next = '0;
    end else if (res > 11'sd255) begin
      value_next = 8'd255;
    end else begin
      value_next = res[7:0];
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      vld_b     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_a     <= in_valid;
      vld_b     <= vld_a;
      out_valid <= vld_b;
    end
  end

endmodule

[design/gradient_noise_fbm_q8.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_fbm_q8: fractal 1D gradient noise from a Q8 time position.
// Results come out in the order the items went in. Throughput: one item per
// cycle, busy is always low. Every octave has its own three-stage lane and
// the normalizer has three more stages behind an input register. Reset
// clears the pipeline valid bits and the registers to their defaults (seed 0,
// one octave, all gradients negative).
// ----------------------------------------------------------------------------
module gradient_noise_fbm_q8 #(
  parameter int MAX_OCTAVES = gnf_pkg::MAX_OCTAVES_DEF,
  parameter int TIME_BITS   = gnf_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [TIME_BITS-1:0]          time_pos,
  output logic                                 done,
  output logic [gnf_pkg::VALUE_W-1:0]          noise_value,
  input  logic                                 wr_en,
  input  logic [gnf_pkg::REG_IDX_W-1:0]        wr_index,
  input  logic [gnf_pkg::CFG_DATA_W-1:0]       wr_data
);

  logic [gnf_pkg::SEED_W-1:0]  seed_byte;
  logic [gnf_pkg::OCT_W-1:0]   octave_count;
  logic [gnf_pkg::SIGN_N-1:0]  sign_bits;
  logic [gnf_pkg::OCT_W-1:0]   oct_eff;
  gnf_pkg::gnf_cfg_t           cfg;

  logic                        accept;
  logic [gnf_pkg::POS_W-1:0]   pos_q;
  logic [3:0]                  vld;

  logic [MAX_OCTAVES-1:0][gnf_pkg::SAMPLE_W-1:0] samples;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_byte    <= '0;
      octave_count <= 4'd1;
      sign_bits    <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        gnf_pkg::REG_SEED:    seed_byte         <= wr_data[gnf_pkg::SEED_W-1:0];
        gnf_pkg::REG_OCTAVES: octave_count      <= wr_data[gnf_pkg::OCT_W-1:0];
        gnf_pkg::REG_SIGN0:   sign_bits[63:0]    <= wr_data;
        gnf_pkg::REG_SIGN1:   sign_bits[127:64]  <= wr_data;
        gnf_pkg::REG_SIGN2:   sign_bits[191:128] <= wr_data;
        gnf_pkg::REG_SIGN3:   sign_bits[255:192] <= wr_data;
        default: ;
      endcase
    end
  end

  assign oct_eff = (octave_count > gnf_pkg::OCT_W'(MAX_OCTAVES))
                 ? gnf_pkg::OCT_W'(MAX_OCTAVES) : octave_count;

  assign cfg.seed  = seed_byte;
  assign cfg.signs = sign_bits;

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q <= time_pos[TIME_BITS-1] ? '0 : time_pos[gnf_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], accept};
    end
  end

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
    gnf_lane #(
      .SHIFT (k)
    ) u_lane (
      .clk    (clk),
      .pos    (pos_q),
      .cfg    (cfg),
      .sample (samples[k])
    );
  end

  gnf_norm #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[3]),
    .samples   (samples),
    .octaves   (oct_eff),
    .out_valid (done),
    .value     (noise_value)
  );

  // A result transfer always traces back to an accepted item.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 7))
    else $error("result without a matching accepted item");

  // With no octaves enabled when the sum stage ran, the result is the midpoint.
  a_zero_octaves_mid: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(oct_eff, 3) == '0)) |-> (noise_value == gnf_pkg::MID_VALUE))
    else $error("zero octaves did not give the midpoint");

endmodule

[verif/gradient_noise_fbm_q8_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_fbm_q8_checker: scoreboard for the fractal noise block.
// Follows every register write, predicts the noise sample of each accepted
// position from its own copy of the registers, and compares each result
// transfer in order with the oldest prediction. It reports the number of
// failures and of predictions still waiting.
// ----------------------------------------------------------------------------
module gradient_noise_fbm_q8_checker #(
  parameter int MAX_OCTAVES = gnf_pkg::MAX_OCTAVES_DEF,
  parameter int TIME_BITS   = gnf_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic signed [TIME_BITS-1:0]    time_pos,
  input  logic                           done,
  input  logic [gnf_pkg::VALUE_W-1:0]    noise_value,
  input  logic                           wr_en,
  input  logic [gnf_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [gnf_pkg::CFG_DATA_W-1:0] wr_data,
  output int                             pending,
  output int                             fail_count
);

  typedef struct {
    logic signed [TIME_BITS-1:0]  pos;
    logic [gnf_pkg::VALUE_W-1:0]  value;
  } noise_expect_t;

  logic [gnf_pkg::SEED_W-1:0] seed_reg;
  logic [gnf_pkg::OCT_W-1:0]  oct_reg;
  logic [gnf_pkg::SIGN_N-1:0] grad_signs;

  noise_expect_t expected_q[$];
  noise_expect_t head;
  int            accepted_cnt;
  int            received_cnt;
  int            mismatch_cnt;

  assign pending    = accepted_cnt - received_cnt;
  assign fail_count = mismatch_cnt;

  // One octave: gradient lookup, cubic fade, lerp and conversion to a
  // signed sample around the midpoint.
  function automatic int lane_sample(longint pos);
    int lat, f, g0, g1, v0, v1, s, n, norm;
    lat  = int'((pos >> 8) & 255);
    f    = int'(pos & 255);
    g0   = grad_signs[(lat ^ seed_reg) & 255] ? 1 : -1;
    g1   = grad_signs[((lat + 1) & 255) ^ seed_reg] ? 1 : -1;
    v0   = g0 * f;
    v1   = g1 * (f - 256);
    s    = (f * f * (768 - 2 * f)) >>> 16;
    n    = v0 + ((s * (v1 - v0)) >>> 8);
    norm = (n >>> 1) + 128;
    if (norm < 0) norm = 0;
    if (norm > 255) norm = 255;
    return norm - 128;
  endfunction

  function automatic logic [gnf_pkg::VALUE_W-1:0] fbm_value(
    logic signed [TIME_BITS-1:0] tp
  );
    longint t;
    int     octs, amp, sum, amp_sum, val;
    t       = tp[TIME_BITS-1] ? 0 : longint'(tp);
    octs    = (oct_reg > MAX_OCTAVES) ? MAX_OCTAVES : int'(oct_reg);
    sum     = 0;
    amp_sum = 0;
    for (int k = 0; k < octs; k++) begin
      amp     = 128 >> k;
      sum    += (lane_sample(t << k) * amp) >>> 7;
      amp_sum += amp;
    end
    if (amp_sum == 0) begin
      val = 128;
    end else begin
      val = (sum * 128) / amp_sum + 128;
      if (val < 0) val = 0;
      if (val > 255) val = 255;
    end
    return val[gnf_pkg::VALUE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      seed_reg     <= '0;
      oct_reg      <= 4'd1;
      grad_signs   <= '0;
      accepted_cnt <= 0;
      received_cnt <= 0;
      mismatch_cnt = 0;
      expected_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          gnf_pkg::REG_SEED:    seed_reg           <= wr_data[gnf_pkg::SEED_W-1:0];
          gnf_pkg::REG_OCTAVES: oct_reg            <= wr_data[gnf_pkg::OCT_W-1:0];
          gnf_pkg::REG_SIGN0:   grad_signs[63:0]   <= wr_data;
          gnf_pkg::REG_SIGN1:   grad_signs[127:64] <= wr_data;
          gnf_pkg::REG_SIGN2:   grad_signs[191:128] <= wr_data;
          gnf_pkg::REG_SIGN3:   grad_signs[255:192] <= wr_data;
          default: ;
        endcase
      end
      if (done) begin
        received_cnt <= received_cnt + 1;
        if (expected_q.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result transfer, noise_value %0d", $realtime,
                     noise_value);
        end else begin
          head = expected_q.pop_front();
          if (noise_value !== head.value) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= 10)
              $display("%0t: noise_value mismatch for time_pos %0d: expected %0d, got %0d",
                       $realtime, head.pos, head.value, noise_value);
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back('{pos: time_pos, value: fbm_value(time_pos)});
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

endmodule

[verif/gradient_noise_fbm_q8_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_fbm_q8_tb: top-level testbench for the fractal noise block.
// Drives directed positions at the field extremes, the lattice wrap, negative
// time and the zero and oversized octave counts, then random positions under
// random register settings with varying sender gaps. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module gradient_noise_fbm_q8_tb;

  localparam int TIME_BITS      = gnf_pkg::TIME_BITS_DEF;
  localparam int END_WAIT       = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEGMENTS       = 11;
  localparam int SEGMENT_ITEMS  = 50;

  localparam logic [gnf_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [gnf_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic signed [TIME_BITS-1:0]    time_pos;
  logic                           done;
  logic [gnf_pkg::VALUE_W-1:0]    noise_value;
  logic                           wr_en;
  logic [gnf_pkg::REG_IDX_W-1:0]  wr_index;
  logic [gnf_pkg::CFG_DATA_W-1:0] wr_data;
  int                             pending;
  int                             fail_count;
  int                             stall_cycles;

  gradient_noise_fbm_q8 dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .time_pos    (time_pos),
    .done        (done),
    .noise_value (noise_value),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  gradient_noise_fbm_q8_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .time_pos    (time_pos),
    .done        (done),
    .noise_value (noise_value),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("gradient_noise_fbm_q8_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(logic signed [TIME_BITS-1:0] tp, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    time_pos <= tp;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_reg(logic [gnf_pkg::REG_IDX_W-1:0] idx,
                         logic [gnf_pkg::CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  // Writes every register, then both unused indexes, which must not disturb
  // anything.
  task automatic apply_config(logic [63:0] seed_data, logic [63:0] oct_data,
                              logic [63:0] s0, logic [63:0] s1,
                              logic [63:0] s2, logic [63:0] s3);
    put_reg(gnf_pkg::REG_SEED, seed_data);
    put_reg(gnf_pkg::REG_OCTAVES, oct_data);
    put_reg(gnf_pkg::REG_SIGN0, s0);
    put_reg(gnf_pkg::REG_SIGN1, s1);
    put_reg(gnf_pkg::REG_SIGN2, s2);
    put_reg(gnf_pkg::REG_SIGN3, s3);
    put_reg(REG_SPARE_A, {$urandom, $urandom});
    put_reg(REG_SPARE_B, {$urandom, $urandom});
    wr_en <= 1'b0;
  endtask

  function automatic logic [63:0] rand_signs();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [gnf_pkg::OCT_W-1:0] rand_octaves();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 18) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  function automatic logic signed [TIME_BITS-1:0] rand_time();
    int          pick;
    logic [31:0] r;
    pick = $urandom_range(99);
    r    = $urandom;
    if (pick < 15) return {1'b1, r[TIME_BITS-2:0]};
    if (pick < 35) return TIME_BITS'($urandom_range(0, 4095));
    if (pick < 55) begin
      case ($urandom_range(5))
        0: r[7:0] = 8'd0;
        1: r[7:0] = 8'd1;
        2: r[7:0] = 8'd127;
        3: r[7:0] = 8'd128;
        4: r[7:0] = 8'd254;
        default: r[7:0] = 8'd255;
      endcase
      return {1'b0, r[TIME_BITS-2:0]};
    end
    return {1'b0, r[TIME_BITS-2:0]};
  endfunction

  initial begin
    int          idle_pct;
    logic [63:0] seed_data;
    logic [63:0] oct_data;

    rst      <= 1'b1;
    start    <= 1'b0;
    time_pos <= '0;
    wr_en    <= 1'b0;
    wr_index <= gnf_pkg::REG_SEED;
    wr_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one octave, every gradient negative.
    send_item(24'h000000, 0);
    send_item(24'h0000FF, 0);
    send_item(24'h000100, 0);
    send_item(24'hFFFFFF, 0);
    send_item(24'h800000, 0);
    send_item(24'h7FFFFF, 0);
    drain();

    apply_config(64'hA5, 64'd8, '1, '0, 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(24'h00FF80, 0);
    send_item(24'h00FFFF, 0);
    send_item(24'h000080, 0);
    send_item(24'h7FFFFF, 0);
    send_item(24'h400000, 0);
    send_item(24'h000001, 0);
    drain();

    apply_config(64'h0, 64'h0, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
    send_item(24'h123456, 0);
    send_item(24'h7FFFFF, 0);
    drain();

    // All-ones data gives seed 255 and an octave count above the maximum.
    apply_config('1, '1, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
    send_item(24'h00FF00, 0);
    send_item(24'h00FFFF, 0);
    send_item(24'h0000C8, 0);
    send_item(24'hFFFFFB, 0);
    send_item(24'h3FFFFF, 0);
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) idle_pct = 30;
      else if (seg < 8) idle_pct = 75;
      else idle_pct = 0;
      seed_data      = {$urandom, $urandom};
      oct_data       = {$urandom, $urandom};
      oct_data[3:0]  = rand_octaves();
      apply_config(seed_data, oct_data, rand_signs(), rand_signs(), rand_signs(),
                   rand_signs());
      for (int n = 0; n < SEGMENT_ITEMS; n++) send_item(rand_time(), idle_pct);
      drain();
    end

    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("gradient_noise_fbm_q8_tb: PASS");
    end else begin
      $display("gradient_noise_fbm_q8_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/gnf_pkg.sv
design/gnf_lane.sv
design/gnf_norm.sv
design/gradient_noise_fbm_q8.sv
verif/gradient_noise_fbm_q8_checker.sv
verif/gradient_noise_fbm_q8_tb.sv
